// ----- src/pmr_pkg.sv -----
package pmr_pkg;

  localparam int unsigned SMALL_LIMIT = 1048576;
  localparam int unsigned NUM_W       = 63;
  localparam int unsigned NUM_BASES   = 7;
  localparam int unsigned BASE_W      = 31;
  localparam int unsigned NUM_DIVS    = 9;
  localparam int unsigned DIV_W       = 5;

  localparam logic [BASE_W-1:0] MR_BASES [NUM_BASES] = '{
    31'd2, 31'd325, 31'd9375, 31'd28178, 31'd450775, 31'd9780504, 31'd1795265022
  };

  localparam logic [DIV_W-1:0] SMALL_DIVS [NUM_DIVS] = '{
    5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29
  };

endpackage

// ----- src/pmr_ram.sv -----
module pmr_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = pmr_pkg::SMALL_LIMIT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- src/pmr_mulmod.sv -----
module pmr_mulmod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pmr_pkg::NUM_W-1:0]  a_i,
  input  logic [pmr_pkg::NUM_W-1:0]  b_i,
  input  logic [pmr_pkg::NUM_W-1:0]  n_i,
  output logic                       done_o,
  output logic [pmr_pkg::NUM_W-1:0]  res_o
);

  localparam int unsigned W = pmr_pkg::NUM_W;

  logic [W-1:0]         r_q, a_q, b_q;
  logic [$clog2(W)-1:0] cnt_q;
  logic                 busy_q, done_q;

  logic [W:0]   dbl, sum, n_ext;
  logic [W-1:0] r1, r_d;

  // one multiplier bit per cycle, msb first, doubling then conditional add
  always_comb begin
    n_ext = {1'b0, n_i};
    dbl   = {r_q, 1'b0};
    r1    = (dbl >= n_ext) ? W'(dbl - n_ext) : dbl[W-1:0];
    sum   = {1'b0, r1} + {1'b0, a_q};
    if (b_q[W-1]) begin
      r_d = (sum >= n_ext) ? W'(sum - n_ext) : sum[W-1:0];
    end else begin
      r_d = r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q    <= '0;
      a_q    <= '0;
      b_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        r_q    <= '0;
        a_q    <= a_i;
        b_q    <= b_i;
        cnt_q  <= ($clog2(W))'(W - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        r_q   <= r_d;
        b_q   <= {b_q[W-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

// ----- src/prime_test_sieve_miller_rabin.sv -----
// Primality tester for 63-bit numbers. After reset the block is busy while it
// builds a one-bit prime table for all values below SMALL_LIMIT: a fill pass
// over all SMALL_LIMIT entries, then a sieve that clears composites one entry
// per cycle while it crosses out the multiples of a prime. An item is taken
// when start is high and busy is low; exactly one result follows, shown on
// is_prime_o for one cycle with done_o high, and it must be captured then since
// the block cannot be held off. Numbers below SMALL_LIMIT are answered from the
// table, other even numbers directly without a test, numbers with a factor from
// 3 to 29 after trial division. The rest run a Miller-Rabin test over seven
// bases on one bit-serial modular multiplier, with up to about 128 products per
// base.
module prime_test_sieve_miller_rabin #(
  parameter int unsigned SMALL_LIMIT = pmr_pkg::SMALL_LIMIT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [pmr_pkg::NUM_W-1:0] number_i,
  output logic                      done_o,
  output logic                      is_prime_o
);

  localparam int unsigned W  = pmr_pkg::NUM_W;
  localparam int unsigned AW = $clog2(SMALL_LIMIT);
  localparam int unsigned KW = $clog2(pmr_pkg::NUM_BASES);
  localparam int unsigned SW = $clog2(W);

  typedef enum logic [4:0] {
    ST_FILL, ST_SIEVE_RD, ST_SIEVE_TST, ST_CROSS, ST_IDLE, ST_CLASS,
    ST_TBL_OUT, ST_TRIAL, ST_TRIAL_END, ST_SPLIT, ST_BASE, ST_BASE_W,
    ST_POW, ST_POW_RX, ST_POW_XX, ST_CHECK, ST_SQ
  } state_e;

  state_e state_q;

  logic [AW-1:0] fill_q, sv_i_q;
  logic [AW:0]   sq_q, j_q;
  logic [AW+1:0] sq_sum, j_sum;
  logic          sq_done, j_done;

  logic [W-1:0]  n_q, d_q, nm1_q, x_q, acc_q, e_q;
  logic [SW-1:0] s_q, rcnt_q, tcnt_q;
  logic [KW-1:0] k_q;
  logic          done_q, is_prime_q;

  logic [pmr_pkg::DIV_W-1:0] rem_q [pmr_pkg::NUM_DIVS];
  logic [pmr_pkg::DIV_W-1:0] rem_d [pmr_pkg::NUM_DIVS];
  logic                      any_div;

  logic          mul_start_q, mul_done;
  logic [W-1:0]  mul_a_q, mul_b_q, mul_res;

  logic          ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic          n_small, last_base;

  // sieve address arithmetic
  always_comb begin
    sq_sum  = {1'b0, sq_q} + {sv_i_q, 2'b00} + (AW+2)'(4);
    sq_done = sq_sum >= (AW+2)'(SMALL_LIMIT);
    j_sum   = {1'b0, j_q} + {1'b0, sv_i_q, 1'b0};
    j_done  = j_sum >= (AW+2)'(SMALL_LIMIT);
  end

  // trial division lanes, one bit of the number per cycle
  always_comb begin
    logic [pmr_pkg::DIV_W:0] t;
    t       = '0;
    any_div = 1'b0;
    for (int l = 0; l < pmr_pkg::NUM_DIVS; l++) begin
      t = {rem_q[l], d_q[W-1]};
      if (t >= {1'b0, pmr_pkg::SMALL_DIVS[l]}) begin
        t = t - {1'b0, pmr_pkg::SMALL_DIVS[l]};
      end
      rem_d[l] = t[pmr_pkg::DIV_W-1:0];
      if (rem_q[l] == '0) begin
        any_div = 1'b1;
      end
    end
  end

  assign n_small   = n_q < W'(SMALL_LIMIT);
  assign last_base = k_q == KW'(pmr_pkg::NUM_BASES - 1);

  assign ram_we    = (state_q == ST_FILL) || (state_q == ST_CROSS);
  assign ram_waddr = (state_q == ST_FILL) ? fill_q : j_q[AW-1:0];
  assign ram_wdata = (state_q == ST_FILL) &&
                     ((fill_q == AW'(2)) || (fill_q[0] && (fill_q != AW'(1))));
  assign ram_raddr = (state_q == ST_SIEVE_RD) ? sv_i_q : n_q[AW-1:0];

  pmr_ram #(
    .WIDTH(1),
    .DEPTH(SMALL_LIMIT)
  ) u_marks (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  pmr_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start_q),
    .a_i    (mul_a_q),
    .b_i    (mul_b_q),
    .n_i    (n_q),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      fill_q      <= '0;
      sv_i_q      <= AW'(3);
      sq_q        <= (AW+1)'(9);
      j_q         <= '0;
      n_q         <= '0;
      d_q         <= '0;
      nm1_q       <= '0;
      x_q         <= '0;
      acc_q       <= '0;
      e_q         <= '0;
      s_q         <= '0;
      rcnt_q      <= '0;
      tcnt_q      <= '0;
      k_q         <= '0;
      done_q      <= 1'b0;
      is_prime_q  <= 1'b0;
      mul_start_q <= 1'b0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      for (int l = 0; l < pmr_pkg::NUM_DIVS; l++) begin
        rem_q[l] <= '0;
      end
    end else begin
      done_q      <= 1'b0;
      mul_start_q <= 1'b0;
      case (state_q)
        ST_FILL: begin
          fill_q <= fill_q + 1'b1;
          if (fill_q == AW'(SMALL_LIMIT - 1)) begin
            state_q <= ST_SIEVE_RD;
          end
        end
        ST_SIEVE_RD: begin
          state_q <= ST_SIEVE_TST;
        end
        ST_SIEVE_TST: begin
          if (ram_rdata) begin
            j_q     <= sq_q;
            state_q <= ST_CROSS;
          end else begin
            sv_i_q  <= sv_i_q + AW'(2);
            sq_q    <= sq_sum[AW:0];
            state_q <= sq_done ? ST_IDLE : ST_SIEVE_RD;
          end
        end
        ST_CROSS: begin
          j_q <= j_sum[AW:0];
          if (j_done) begin
            sv_i_q  <= sv_i_q + AW'(2);
            sq_q    <= sq_sum[AW:0];
            state_q <= sq_done ? ST_IDLE : ST_SIEVE_RD;
          end
        end
        ST_IDLE: begin
          if (start) begin
            n_q     <= number_i;
            state_q <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          if (n_small) begin
            state_q <= ST_TBL_OUT;
          end else if (!n_q[0]) begin
            is_prime_q <= 1'b0;
            done_q     <= 1'b1;
            state_q    <= ST_IDLE;
          end else begin
            d_q    <= n_q;
            tcnt_q <= SW'(W - 1);
            for (int l = 0; l < pmr_pkg::NUM_DIVS; l++) begin
              rem_q[l] <= '0;
            end
            state_q <= ST_TRIAL;
          end
        end
        ST_TBL_OUT: begin
          is_prime_q <= ram_rdata;
          done_q     <= 1'b1;
          state_q    <= ST_IDLE;
        end
        ST_TRIAL: begin
          for (int l = 0; l < pmr_pkg::NUM_DIVS; l++) begin
            rem_q[l] <= rem_d[l];
          end
          d_q    <= {d_q[W-2:0], 1'b0};
          tcnt_q <= tcnt_q - 1'b1;
          if (tcnt_q == '0) begin
            state_q <= ST_TRIAL_END;
          end
        end
        ST_TRIAL_END: begin
          if (any_div) begin
            is_prime_q <= 1'b0;
            done_q     <= 1'b1;
            state_q    <= ST_IDLE;
          end else begin
            d_q     <= n_q - 1'b1;
            nm1_q   <= n_q - 1'b1;
            s_q     <= '0;
            state_q <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          if (!d_q[0]) begin
            d_q <= {1'b0, d_q[W-1:1]};
            s_q <= s_q + 1'b1;
          end else begin
            k_q     <= '0;
            state_q <= ST_BASE;
          end
        end
        ST_BASE: begin
          mul_a_q     <= W'(1);
          mul_b_q     <= W'(pmr_pkg::MR_BASES[k_q]);
          mul_start_q <= 1'b1;
          state_q     <= ST_BASE_W;
        end
        ST_BASE_W: begin
          if (mul_done) begin
            if (mul_res == '0) begin
              if (last_base) begin
                is_prime_q <= 1'b1;
                done_q     <= 1'b1;
                state_q    <= ST_IDLE;
              end else begin
                k_q     <= k_q + 1'b1;
                state_q <= ST_BASE;
              end
            end else begin
              x_q     <= mul_res;
              acc_q   <= W'(1);
              e_q     <= d_q;
              state_q <= ST_POW;
            end
          end
        end
        ST_POW: begin
          if (e_q == '0) begin
            x_q     <= acc_q;
            state_q <= ST_CHECK;
          end else if (e_q[0]) begin
            mul_a_q     <= acc_q;
            mul_b_q     <= x_q;
            mul_start_q <= 1'b1;
            state_q     <= ST_POW_RX;
          end else begin
            mul_a_q     <= x_q;
            mul_b_q     <= x_q;
            mul_start_q <= 1'b1;
            state_q     <= ST_POW_XX;
          end
        end
        ST_POW_RX: begin
          if (mul_done) begin
            acc_q       <= mul_res;
            mul_a_q     <= x_q;
            mul_b_q     <= x_q;
            mul_start_q <= 1'b1;
            state_q     <= ST_POW_XX;
          end
        end
        ST_POW_XX: begin
          if (mul_done) begin
            x_q     <= mul_res;
            e_q     <= {1'b0, e_q[W-1:1]};
            state_q <= ST_POW;
          end
        end
        ST_CHECK: begin
          if ((x_q == W'(1)) || (x_q == nm1_q)) begin
            if (last_base) begin
              is_prime_q <= 1'b1;
              done_q     <= 1'b1;
              state_q    <= ST_IDLE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= ST_BASE;
            end
          end else if (s_q <= SW'(1)) begin
            is_prime_q <= 1'b0;
            done_q     <= 1'b1;
            state_q    <= ST_IDLE;
          end else begin
            rcnt_q      <= SW'(1);
            mul_a_q     <= x_q;
            mul_b_q     <= x_q;
            mul_start_q <= 1'b1;
            state_q     <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (mul_done) begin
            if (mul_res == nm1_q) begin
              if (last_base) begin
                is_prime_q <= 1'b1;
                done_q     <= 1'b1;
                state_q    <= ST_IDLE;
              end else begin
                k_q     <= k_q + 1'b1;
                state_q <= ST_BASE;
              end
            end else if ((rcnt_q + 1'b1) < s_q) begin
              rcnt_q      <= rcnt_q + 1'b1;
              mul_a_q     <= mul_res;
              mul_b_q     <= mul_res;
              mul_start_q <= 1'b1;
            end else begin
              is_prime_q <= 1'b0;
              done_q     <= 1'b1;
              state_q    <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy       = state_q != ST_IDLE;
  assign done_o     = done_q;
  assign is_prime_o = is_prime_q;

endmodule

// ----- src/pmr_checker.sv -----
module pmr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("not busy after accepted transaction");

  // a result never comes while busy
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while busy");

  // a result is a single-cycle strobe
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // a result follows a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(busy))
    else $error("result without preceding work");

endmodule

bind prime_test_sieve_miller_rabin pmr_checker u_pmr_checker (.*);
